[rtl/frp_pkg.sv]
// shared types and codes for the flit packet reassembler
package frp_pkg;

  localparam int unsigned FLIT_W  = 34;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_CODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_TYPE = 2'd3;

  typedef enum logic [2:0] {
    EVT_HEAD      = 3'd0,
    EVT_BODY      = 3'd1,
    EVT_DONE      = 3'd2,
    EVT_BODY_ERR  = 3'd3,
    EVT_TAIL_ERR  = 3'd4,
    EVT_IGNORED   = 3'd5
  } evt_t;

  typedef struct packed {
    logic [KIND_W-1:0] head_code;
    logic [KIND_W-1:0] body_code;
    logic [KIND_W-1:0] tail_code;
    logic [TYPE_W-1:0] result_type_code;
  } cfg_t;

  typedef struct packed {
    evt_t              event_res;
    logic [WORD_W-1:0] word_value;
    logic [CNT_W-1:0]  word_index;
    logic [TYPE_W-1:0] pkt_type;
    logic              is_result;
    logic              count_mismatch;
    logic [CNT_W-1:0]  words_received;
  } res_t;

endpackage

[rtl/frp_cfg_regs.sv]
// configuration registers for kind codes and the result packet type
module frp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output frp_pkg::cfg_t                     cfg
);

  frp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_code        <= 2'd0;
      cfg_r.body_code        <= 2'd1;
      cfg_r.tail_code        <= 2'd2;
      cfg_r.result_type_code <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        frp_pkg::REG_HEAD_CODE:   cfg_r.head_code        <= cfg_wdata[frp_pkg::KIND_W-1:0];
        frp_pkg::REG_BODY_CODE:   cfg_r.body_code        <= cfg_wdata[frp_pkg::KIND_W-1:0];
        frp_pkg::REG_TAIL_CODE:   cfg_r.tail_code        <= cfg_wdata[frp_pkg::KIND_W-1:0];
        frp_pkg::REG_RESULT_TYPE: cfg_r.result_type_code <= cfg_wdata[frp_pkg::TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/frp_core.sv]
// packet state registers and per-flit decode
module frp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [frp_pkg::FLIT_W-1:0]    flit,
  input  frp_pkg::cfg_t                 cfg,
  output frp_pkg::res_t                 res
);

  logic                          rebuilding_r, rebuilding_nxt;
  logic [frp_pkg::TYPE_W-1:0]    type_r, type_nxt;
  logic [frp_pkg::CNT_W-1:0]     expected_r, expected_nxt;
  logic [frp_pkg::CNT_W-1:0]     received_r, received_nxt;

  logic [frp_pkg::KIND_W-1:0]    kind;
  logic [frp_pkg::TYPE_W-1:0]    ftype;

  assign kind  = flit[frp_pkg::FLIT_W-1 -: frp_pkg::KIND_W];
  assign ftype = flit[27:24];

  always_comb begin
    rebuilding_nxt = rebuilding_r;
    type_nxt       = type_r;
    expected_nxt   = expected_r;
    received_nxt   = received_r;

    res                = '0;
    res.event_res      = frp_pkg::EVT_IGNORED;
    res.pkt_type       = type_r;

    if (kind == cfg.head_code) begin
      res.event_res  = frp_pkg::EVT_HEAD;
      res.pkt_type   = ftype;
      rebuilding_nxt = 1'b1;
      type_nxt       = ftype;
      expected_nxt   = flit[frp_pkg::CNT_W-1:0];
      received_nxt   = '0;
    end else if (kind == cfg.body_code) begin
      if (!rebuilding_r) begin
        res.event_res = frp_pkg::EVT_BODY_ERR;
      end else begin
        res.event_res  = frp_pkg::EVT_BODY;
        res.word_value = flit[frp_pkg::WORD_W-1:0];
        res.word_index = received_r;
        if (received_r != frp_pkg::CNT_MAX) begin
          received_nxt = received_r + frp_pkg::CNT_W'(1);
        end
      end
    end else if (kind == cfg.tail_code) begin
      if (!rebuilding_r) begin
        res.event_res = frp_pkg::EVT_TAIL_ERR;
      end else begin
        res.event_res      = frp_pkg::EVT_DONE;
        res.is_result      = (type_r == cfg.result_type_code);
        res.count_mismatch = (received_r != expected_r);
        res.words_received = received_r;
        rebuilding_nxt     = 1'b0;
        type_nxt           = '0;
        expected_nxt       = '0;
        received_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rebuilding_r <= 1'b0;
      type_r       <= '0;
      expected_r   <= '0;
      received_r   <= '0;
    end else if (accept) begin
      rebuilding_r <= rebuilding_nxt;
      type_r       <= type_nxt;
      expected_r   <= expected_nxt;
      received_r   <= received_nxt;
    end
  end

endmodule

[rtl/frp_out_buf.sv]
// result register with a skid stage
module frp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  frp_pkg::res_t    push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output frp_pkg::res_t    out_data
);

  logic          main_valid_r;
  logic          skid_valid_r;
  frp_pkg::res_t main_r;
  frp_pkg::res_t skid_r;
  logic          pop;

  assign pop      = main_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push && (!main_valid_r || pop)) begin
        main_valid_r <= 1'b1;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end else if (pop) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          main_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!main_valid_r || pop)) begin
      main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end else if (pop && skid_valid_r) begin
      main_r <= skid_r;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

[rtl/flit_packet_reassembler.sv]
// top level of the flit packet reassembler
// Takes one 34-bit flit per transaction and returns exactly one result per
// flit. The result shows on the out ports in the cycle after the flit is
// accepted when the result register is free, or later while earlier results
// wait on out_ready. A flit can be accepted in every cycle while a result slot is free:
// the kind decode, the count update and the compares are a single pass of
// logic from the packet state registers into a result register, and a skid
// stage behind that register lets the input keep accepting while a result
// waits on out_ready. in_ready drops only when both result slots are full.
// Kind codes and the result packet type are written through the cfg port; the user must
// do so only while no flit is in flight, which the block itself does not enforce.
module flit_packet_reassembler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [frp_pkg::FLIT_W-1:0]        in_flit_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_event_res,
  output logic [frp_pkg::WORD_W-1:0]        out_word_value,
  output logic [frp_pkg::CNT_W-1:0]         out_word_index,
  output logic [frp_pkg::TYPE_W-1:0]        out_pkt_type,
  output logic                              out_is_result,
  output logic                              out_count_mismatch,
  output logic [frp_pkg::CNT_W-1:0]         out_words_received
);

  frp_pkg::cfg_t cfg;
  frp_pkg::res_t core_res;
  frp_pkg::res_t out_res;
  logic          accept;

  assign accept = in_valid && in_ready;

  frp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  frp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .flit   (in_flit_word),
    .cfg    (cfg),
    .res    (core_res)
  );

  frp_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_event_res      = out_res.event_res;
  assign out_word_value     = out_res.word_value;
  assign out_word_index     = out_res.word_index;
  assign out_pkt_type       = out_res.pkt_type;
  assign out_is_result      = out_res.is_result;
  assign out_count_mismatch = out_res.count_mismatch;
  assign out_words_received = out_res.words_received;

endmodule

[rtl/frp_checker.sv]
// port-level checks for the flit packet reassembler, bound to the top level
module frp_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [2:0]                        out_event_res,
  input  logic [frp_pkg::WORD_W-1:0]        out_word_value,
  input  logic [frp_pkg::CNT_W-1:0]         out_word_index,
  input  logic                              out_is_result,
  input  logic                              out_count_mismatch,
  input  logic [frp_pkg::CNT_W-1:0]         out_words_received
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_word_value) && $stable(out_word_index)
      && $stable(out_words_received))
    else $error("stalled result changed");

  a_evt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= frp_pkg::EVT_IGNORED)
    else $error("undefined event code");

  a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != frp_pkg::EVT_BODY
      |-> out_word_value == '0 && out_word_index == '0)
    else $error("word fields set outside a body transaction");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != frp_pkg::EVT_DONE
      |-> !out_is_result && !out_count_mismatch && out_words_received == '0)
    else $error("done fields set outside packet done");

  // out_valid is always high in the next cycle after an accepted flit
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted flit produced no result");

endmodule

bind flit_packet_reassembler frp_checker u_frp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_event_res      (out_event_res),
  .out_word_value     (out_word_value),
  .out_word_index     (out_word_index),
  .out_is_result      (out_is_result),
  .out_count_mismatch (out_count_mismatch),
  .out_words_received (out_words_received)
);

[verif/flit_packet_reassembler_tb.sv]
// self-checking testbench for the flit packet reassembler with an in-line packet predictor
module flit_packet_reassembler_tb;

  localparam int PHASES = 7;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int STALL_LIMIT = 5000;

  class reassembly_scoreboard;
    frp_pkg::cfg_t                      codes;
    logic                               rebuilding;
    logic [frp_pkg::TYPE_W-1:0]         cur_type;
    logic [frp_pkg::CNT_W-1:0]          want_count;
    logic [frp_pkg::CNT_W-1:0]          got_count;
    frp_pkg::res_t                      pending_results[$];
    int                                 errors;

    function new();
      codes = '{2'd0, 2'd1, 2'd2, 4'd0};
      clear_packet();
      errors = 0;
    endfunction

    function void clear_packet();
      rebuilding = 1'b0;
      cur_type = '0;
      want_count = '0;
      got_count = '0;
    endfunction

    function void set_reg(logic [frp_pkg::CFG_IDX_W-1:0] idx,
                          logic [frp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        frp_pkg::REG_HEAD_CODE:   codes.head_code = data[frp_pkg::KIND_W-1:0];
        frp_pkg::REG_BODY_CODE:   codes.body_code = data[frp_pkg::KIND_W-1:0];
        frp_pkg::REG_TAIL_CODE:   codes.tail_code = data[frp_pkg::KIND_W-1:0];
        frp_pkg::REG_RESULT_TYPE: codes.result_type_code = data[frp_pkg::TYPE_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // predicts the result of one accepted flit
    function void note_flit(logic [frp_pkg::FLIT_W-1:0] flit);
      logic [frp_pkg::KIND_W-1:0] kind;
      frp_pkg::res_t want;
      kind = flit[33:32];
      want = '0;
      want.event_res = frp_pkg::EVT_IGNORED;
      if (kind == codes.head_code) begin
        rebuilding = 1'b1;
        cur_type = flit[27:24];
        want_count = flit[frp_pkg::CNT_W-1:0];
        got_count = '0;
        want.event_res = frp_pkg::EVT_HEAD;
      end else if (kind == codes.body_code) begin
        if (!rebuilding) begin
          want.event_res = frp_pkg::EVT_BODY_ERR;
        end else begin
          want.event_res = frp_pkg::EVT_BODY;
          want.word_value = flit[frp_pkg::WORD_W-1:0];
          want.word_index = got_count;
          if (got_count != frp_pkg::CNT_MAX) got_count = got_count + 1'b1;
        end
      end else if (kind == codes.tail_code) begin
        if (!rebuilding) begin
          want.event_res = frp_pkg::EVT_TAIL_ERR;
        end else begin
          want.event_res = frp_pkg::EVT_DONE;
          want.is_result = (cur_type == codes.result_type_code);
          want.count_mismatch = (got_count != want_count);
          want.words_received = got_count;
        end
      end
      want.pkt_type = cur_type;
      if (want.event_res == frp_pkg::EVT_DONE) clear_packet();
      pending_results.insert(pending_results.size(), want);
    endfunction

    function void compare_field(string name, logic [frp_pkg::WORD_W-1:0] want,
                                logic [frp_pkg::WORD_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frp_pkg::res_t got);
      frp_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no flit pending");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
      compare_field("word_value", want.word_value, got.word_value);
      compare_field("word_index", 32'(want.word_index), 32'(got.word_index));
      compare_field("pkt_type", 32'(want.pkt_type), 32'(got.pkt_type));
      compare_field("is_result", 32'(want.is_result), 32'(got.is_result));
      compare_field("count_mismatch", 32'(want.count_mismatch),
                    32'(got.count_mismatch));
      compare_field("words_received", 32'(want.words_received),
                    32'(got.words_received));
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [frp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [frp_pkg::FLIT_W-1:0]     in_flit_word;
  logic                           out_valid;
  logic                           out_ready;
  logic [2:0]                     out_event_res;
  logic [frp_pkg::WORD_W-1:0]     out_word_value;
  logic [frp_pkg::CNT_W-1:0]      out_word_index;
  logic [frp_pkg::TYPE_W-1:0]     out_pkt_type;
  logic                           out_is_result;
  logic                           out_count_mismatch;
  logic [frp_pkg::CNT_W-1:0]      out_words_received;

  reassembly_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            flits_sent;
  int            stall_cycles;
  frp_pkg::cfg_t settings [PHASES];

  flit_packet_reassembler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_flit_word       (in_flit_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_word_value     (out_word_value),
    .out_word_index     (out_word_index),
    .out_pkt_type       (out_pkt_type),
    .out_is_result      (out_is_result),
    .out_count_mismatch (out_count_mismatch),
    .out_words_received (out_words_received)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    frp_pkg::res_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.event_res = frp_pkg::evt_t'(out_event_res);
        got.word_value = out_word_value;
        got.word_index = out_word_index;
        got.pkt_type = out_pkt_type;
        got.is_result = out_is_result;
        got.count_mismatch = out_count_mismatch;
        got.words_received = out_words_received;
        sb.check_result(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_flit(logic [frp_pkg::FLIT_W-1:0] flit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_flit_word <= flit;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_flit(flit);
    flits_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    logic [frp_pkg::TYPE_W-1:0] ptype;
    logic [frp_pkg::CNT_W-1:0]  count;
    logic [frp_pkg::WORD_W-1:0] word;
    int                         nbody;
    int                         pick;
    ptype = 4'($urandom);
    if ($urandom_range(2) == 0) ptype = sb.codes.result_type_code;
    pick = $urandom_range(99);
    if (pick < 90) count = 24'($urandom_range(6));
    else if (pick < 95) count = frp_pkg::CNT_MAX;
    else count = 24'($urandom);
    nbody = ($urandom_range(3) != 0 && count <= 6) ? int'(count) : $urandom_range(8);
    send_flit({sb.codes.head_code, 4'($urandom), ptype, count});
    for (int i = 0; i < nbody; i++) begin
      pick = $urandom_range(9);
      word = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      send_flit({sb.codes.body_code, word});
    end
    if ($urandom_range(9) != 0) send_flit({sb.codes.tail_code, 32'($urandom)});
  endtask

  task automatic drive_reg(logic [frp_pkg::CFG_IDX_W-1:0] idx,
                           logic [frp_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_codes(frp_pkg::cfg_t c);
    drive_reg(frp_pkg::REG_HEAD_CODE, frp_pkg::CFG_DATA_W'(c.head_code));
    drive_reg(frp_pkg::REG_BODY_CODE, frp_pkg::CFG_DATA_W'(c.body_code));
    drive_reg(frp_pkg::REG_TAIL_CODE, frp_pkg::CFG_DATA_W'(c.tail_code));
    drive_reg(frp_pkg::REG_RESULT_TYPE, c.result_type_code);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_directed();
    send_flit({2'd1, 32'hFFFF_FFFF});
    send_flit({2'd2, 32'h0000_0000});
    send_flit({2'd3, 32'hFFFF_FFFF});
    send_flit({2'd0, 4'hF, 4'h0, 24'h000000});
    send_flit({2'd2, 32'h1234_5678});
    send_flit({2'd0, 4'h0, 4'hF, 24'hFFFFFF});
    send_flit({2'd1, 32'h0000_0000});
    send_flit({2'd1, 32'hFFFF_FFFF});
    send_flit({2'd2, 32'hFFFF_FFFF});
    send_flit({2'd0, 4'h5, 4'h3, 24'h000002});
    send_flit({2'd1, 32'hA5A5_A5A5});
    send_flit({2'd0, 4'hA, 4'h4, 24'h000001});
    send_flit({2'd1, 32'h5A5A_5A5A});
    send_flit({2'd2, 32'h0000_0000});
    send_flit({2'd0, 4'h1, 4'h0, 24'h000001});
    send_flit({2'd3, 32'h0F0F_0F0F});
    send_flit({2'd2, 32'hF0F0_F0F0});
    send_flit({2'd0, 4'h2, 4'h8, 24'h800000});
    send_flit({2'd3, 32'h0000_0000});
    send_flit({2'd1, 32'h8000_0001});
    send_flit({2'd2, 32'h0000_0000});
    send_flit({frp_pkg::FLIT_W{1'b0}});
    send_flit({frp_pkg::FLIT_W{1'b1}});
  endtask

  initial begin
    int target;
    sb = new();
    settings[0] = '{2'd0, 2'd1, 2'd2, 4'd0};
    settings[1] = '{2'd3, 2'd0, 2'd1, 4'd15};
    settings[2] = '{2'd1, 2'd2, 2'd3, 4'd7};
    settings[3] = '{2'd2, 2'd2, 2'd0, 4'd5};
    settings[4] = '{2'd0, 2'd3, 2'd3, 4'd0};
    settings[5] = '{2'd3, 2'd3, 2'd3, 4'd15};
    settings[6] = '{2'd2, 2'd1, 2'd0, 4'd10};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_flit_word = '0;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    flits_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 47;
      end else if (p < 5) begin
        send_idle_pct = 47;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      apply_codes(settings[p]);
      if (p == 0) send_directed();
      target = flits_sent + RANDOM_PER_PHASE;
      while (flits_sent < target) begin
        if ($urandom_range(99) < 85) send_packet();
        else send_flit({2'($urandom), 32'($urandom)});
      end
    end
    drain();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
